// ----- design/edf_task_scheduler_defines.svh -----
// assertion macros shared by the scheduler rtl
// expects clk and rst_n in the scope of each use
`ifndef EDF_TASK_SCHEDULER_DEFINES_SVH
`define EDF_TASK_SCHEDULER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define EDF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define EDF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/edf_pkg.sv -----
// shared types, widths and codes of the edf task scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

  localparam int MAX_TASKS    = 16;
  localparam int TIME_BITS    = 32;
  localparam int IDX_W        = $clog2(MAX_TASKS);
  localparam int CNT_W        = $clog2(MAX_TASKS + 1);
  localparam int EXEC_W       = 16;
  localparam int PERIOD_W     = 16;
  localparam int TASK_COUNT_W = 5;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  // item kind carried on tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // register word index, taken from paddr[2]
  localparam logic REG_TASK_COUNT = 1'b0;
  localparam logic REG_HORIZON    = 1'b1;

  localparam logic [TASK_COUNT_W-1:0] TASK_COUNT_RST = TASK_COUNT_W'(1);
  localparam time_t                   HORIZON_RST    = TIME_BITS'(1000);

  // one task table word
  typedef struct packed {
    logic [EXEC_W-1:0]   exec_time;
    logic [PERIOD_W-1:0] period;
    time_t               deadline;
  } task_entry_t;

  // input item payload, first field in the high bits
  typedef struct packed {
    logic [3:0]          pad;
    logic [PERIOD_W-1:0] period;
    logic [EXEC_W-1:0]   exec_time;
    logic [IDX_W-1:0]    task_index;
  } in_data_t;

  // result item payload, first field in the high bits
  typedef struct packed {
    logic             pad;
    time_t            current_time;
    logic             finished;
    logic             deadline_missed;
    logic             cpu_idle;
    logic [IDX_W-1:0] running_task;
  } out_data_t;

  // saturating add of a time and a 16 bit span
  function automatic time_t sat_add(time_t a, logic [15:0] b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + (TIME_BITS + 1)'(b);
    return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/edf_task_scheduler.sv -----
// edf task scheduler top level, uses edf_pkg and the assertion macro header
// load item: writes the entry and restarts, then reports through the done state.
// tick item: a pick covers the tasks in use with the
// one-entry-a-cycle scan of the task table memory; one item at a time.
// reset is synchronous: clears control state, flags and the table's valid bits
// at once, with no clearing pass over the memory; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "edf_task_scheduler_defines.svh"

module edf_task_scheduler (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [39:0]                      in_tdata,   // task_index, exec_time, period
  input  wire                              in_tuser,   // action
  // result channel
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [39:0]                      out_tdata,  // running_task, cpu_idle,
                                                       // deadline_missed, finished,
                                                       // current_time
  // configuration port
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [edf_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire  [edf_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [edf_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;
  localparam logic [2:0] ST_WB    = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [1:0] CTX_FIRST = 2'd0;
  localparam logic [1:0] CTX_IDLE  = 2'd1;
  localparam logic [1:0] CTX_END   = 2'd2;

  // configuration registers
  logic [edf_pkg::TASK_COUNT_W-1:0] task_count_r;
  edf_pkg::time_t                   horizon_r;

  // control state
  logic [2:0]                  state_r, state_nxt;
  logic [1:0]                  ctx_r, ctx_nxt;
  logic [edf_pkg::CNT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic [edf_pkg::CNT_W-1:0]   scan_lim_r, scan_lim_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic                        found_r, found_nxt;
  edf_pkg::time_t              now_r, now_nxt;
  edf_pkg::time_t              job_end_r, job_end_nxt;
  logic [edf_pkg::IDX_W-1:0]   chosen_r, chosen_nxt;
  logic                        idle_r, idle_nxt;
  logic                        miss_r, miss_nxt;
  logic                        started_r, started_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [edf_pkg::MAX_TASKS-1:0] valid_r;

  // payload registers
  edf_pkg::time_t              best_dl_r, best_dl_nxt;
  logic [edf_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [edf_pkg::EXEC_W-1:0]  best_exec_r, best_exec_nxt;
  edf_pkg::time_t              wb_dl_r, wb_dl_nxt;
  edf_pkg::out_data_t          out_r, out_nxt;
  logic [edf_pkg::IDX_W-1:0]   rd_idx_r;

  // task table memory
  edf_pkg::task_entry_t        mem [edf_pkg::MAX_TASKS];
  edf_pkg::task_entry_t        rdata_r;
  logic                        rd_ok_r;
  logic                        rd_en;
  logic [edf_pkg::IDX_W-1:0]   rd_addr;
  logic                        mem_we;
  logic [edf_pkg::IDX_W-1:0]   mem_waddr;
  edf_pkg::task_entry_t        mem_wdata;

  edf_pkg::in_data_t           in_d;
  edf_pkg::task_entry_t        ent;
  logic                        in_acc;
  logic                        cfg_wr;
  logic [edf_pkg::CNT_W-1:0]   used_n;
  logic [edf_pkg::CNT_W-1:0]   first_n;
  logic                        elig;
  logic                        upd;

  assign in_d       = edf_pkg::in_data_t'(in_tdata);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // entries never loaded read as zero
  assign ent = rd_ok_r ? rdata_r : '0;

  // tasks in use, clipped to the table size
  always_comb begin
    if (edf_pkg::CNT_W'(task_count_r) > edf_pkg::CNT_W'(edf_pkg::MAX_TASKS)) begin
      used_n = edf_pkg::CNT_W'(edf_pkg::MAX_TASKS);
    end else begin
      used_n = edf_pkg::CNT_W'(task_count_r);
    end
    first_n = (used_n == '0) ? edf_pkg::CNT_W'(1) : used_n;
  end

  // candidate test: first pick looks at deadlines only, later picks need release
  always_comb begin
    elig = (ctx_r == CTX_FIRST)
        || (ent.deadline < edf_pkg::time_t'(ent.period))
        || (now_r >= (ent.deadline - edf_pkg::time_t'(ent.period)));
    upd  = rd_pend_r && elig && (!found_r || (ent.deadline < best_dl_r));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= edf_pkg::TASK_COUNT_RST;
      horizon_r    <= edf_pkg::HORIZON_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        edf_pkg::REG_TASK_COUNT: task_count_r <= cfg_pwdata[edf_pkg::TASK_COUNT_W-1:0];
        edf_pkg::REG_HORIZON:    horizon_r    <= edf_pkg::time_t'(cfg_pwdata);
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_paddr[2])
      edf_pkg::REG_TASK_COUNT: cfg_prdata = edf_pkg::CFG_DATA_W'(task_count_r);
      edf_pkg::REG_HORIZON:    cfg_prdata = edf_pkg::CFG_DATA_W'(horizon_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ctx_nxt       = ctx_r;
    scan_cnt_nxt  = scan_cnt_r;
    scan_lim_nxt  = scan_lim_r;
    rd_pend_nxt   = 1'b0;
    found_nxt     = found_r;
    now_nxt       = now_r;
    job_end_nxt   = job_end_r;
    chosen_nxt    = chosen_r;
    idle_nxt      = idle_r;
    miss_nxt      = miss_r;
    started_nxt   = started_r;
    best_dl_nxt   = best_dl_r;
    best_idx_nxt  = best_idx_r;
    best_exec_nxt = best_exec_r;
    wb_dl_nxt     = wb_dl_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_en         = 1'b0;
    rd_addr       = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == edf_pkg::ACT_LOAD) begin
            // write the entry and restart
            mem_we      = 1'b1;
            mem_waddr   = in_d.task_index;
            mem_wdata   = '{exec_time: in_d.exec_time, period: in_d.period,
                            deadline: edf_pkg::time_t'(in_d.period)};
            now_nxt     = '0;
            job_end_nxt = '0;
            chosen_nxt  = '0;
            idle_nxt    = 1'b0;
            miss_nxt    = 1'b0;
            started_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else if (miss_r) begin
            state_nxt = ST_DONE;
          end else if (!started_r) begin
            ctx_nxt      = CTX_FIRST;
            scan_lim_nxt = first_n;
            scan_cnt_nxt = '0;
            found_nxt    = 1'b0;
            state_nxt    = ST_SCAN;
          end else if (now_r < horizon_r && now_r != edf_pkg::TIME_MAX) begin
            if (idle_r) begin
              ctx_nxt      = CTX_IDLE;
              scan_lim_nxt = used_n;
              scan_cnt_nxt = '0;
              found_nxt    = 1'b0;
              state_nxt    = ST_SCAN;
            end else begin
              state_nxt = ST_CHECK;
            end
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        // issue one read a cycle, compare the entry that came back
        if (scan_cnt_r != scan_lim_r) begin
          rd_en        = 1'b1;
          rd_addr      = scan_cnt_r[edf_pkg::IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + edf_pkg::CNT_W'(1);
          rd_pend_nxt  = 1'b1;
        end
        if (upd) begin
          found_nxt     = 1'b1;
          best_dl_nxt   = ent.deadline;
          best_idx_nxt  = rd_idx_r;
          best_exec_nxt = ent.exec_time;
        end
        if (scan_cnt_r == scan_lim_r && !rd_pend_r) begin
          state_nxt = ST_PICK;
        end
      end

      ST_PICK: begin
        unique case (ctx_r)
          CTX_FIRST: begin
            chosen_nxt  = best_idx_r;
            job_end_nxt = edf_pkg::time_t'(best_exec_r);
            now_nxt     = edf_pkg::time_t'(1);
            started_nxt = 1'b1;
            idle_nxt    = 1'b0;
            state_nxt   = ST_DONE;
          end
          CTX_IDLE: begin
            if (found_r) begin
              chosen_nxt  = best_idx_r;
              idle_nxt    = 1'b0;
              job_end_nxt = edf_pkg::sat_add(now_r, best_exec_r);
            end
            state_nxt = ST_CHECK;
          end
          default: begin
            if (found_r) begin
              chosen_nxt  = best_idx_r;
              idle_nxt    = 1'b0;
              job_end_nxt = edf_pkg::sat_add(now_r, best_exec_r);
            end else begin
              idle_nxt = 1'b1;
            end
            now_nxt   = now_r + edf_pkg::time_t'(1);
            state_nxt = ST_DONE;
          end
        endcase
      end

      ST_CHECK: begin
        // running job ends on this tick: fetch its entry
        if (!idle_r && now_r == job_end_r) begin
          rd_en     = 1'b1;
          rd_addr   = chosen_r;
          state_nxt = ST_EVAL;
        end else begin
          now_nxt   = now_r + edf_pkg::time_t'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_EVAL: begin
        // late finish stops the run, else move the deadline a period on
        if (now_r > ent.deadline) begin
          miss_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          wb_dl_nxt = edf_pkg::sat_add(ent.deadline, ent.period);
          state_nxt = ST_WB;
        end
      end

      ST_WB: begin
        // read data still holds the chosen entry
        mem_we       = 1'b1;
        mem_waddr    = chosen_r;
        mem_wdata    = '{exec_time: ent.exec_time, period: ent.period, deadline: wb_dl_r};
        ctx_nxt      = CTX_END;
        scan_lim_nxt = used_n;
        scan_cnt_nxt = '0;
        found_nxt    = 1'b0;
        state_nxt    = ST_SCAN;
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_nxt.pad             = 1'b0;
          out_nxt.running_task    = chosen_r;
          out_nxt.cpu_idle        = idle_r;
          out_nxt.deadline_missed = miss_r;
          out_nxt.finished        = miss_r || (now_r >= horizon_r)
                                 || (now_r == edf_pkg::TIME_MAX);
          out_nxt.current_time    = now_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctx_r       <= CTX_FIRST;
      scan_cnt_r  <= '0;
      scan_lim_r  <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      now_r       <= '0;
      job_end_r   <= '0;
      chosen_r    <= '0;
      idle_r      <= 1'b0;
      miss_r      <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      scan_lim_r  <= scan_lim_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      now_r       <= now_nxt;
      job_end_r   <= job_end_nxt;
      chosen_r    <= chosen_nxt;
      idle_r      <= idle_nxt;
      miss_r      <= miss_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_dl_r   <= best_dl_nxt;
    best_idx_r  <= best_idx_nxt;
    best_exec_r <= best_exec_nxt;
    wb_dl_r     <= wb_dl_nxt;
    out_r       <= out_nxt;
  end

  // task table: one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      rd_ok_r  <= valid_r[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  // checks
  `EDF_ASSERT_ALWAYS(a_no_rw_overlap, !(mem_we && rd_en), "table read and write in one cycle")
  `EDF_ASSERT_ALWAYS(a_scan_bound, scan_cnt_r <= scan_lim_r, "scan index past the task count")
  `EDF_ASSERT_IMPL(a_miss_holds_time, $rose(miss_r), $stable(now_r), "clock moved on a miss")
  `EDF_ASSERT_IMPL(a_miss_finished, out_valid_r && out_r.deadline_missed, out_r.finished,
                   "missed deadline not reported as finished")

endmodule

`default_nettype wire
